// ----- hw/rtl/breakpoint_envelope_interpolator_macros.svh -----
// ----------------------------------------------------------------------------
// breakpoint envelope interpolator assertion macros
// shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is asserted
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_ENVELOPE_INTERPOLATOR_MACROS_SVH
`define BREAKPOINT_ENVELOPE_INTERPOLATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BEI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bei assertion failed");

// consequent checked in the cycle after the antecedent
`define BEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bei assertion failed");

`endif

// ----- hw/rtl/bei_pkg.sv -----
// ----------------------------------------------------------------------------
// bei_pkg
// item codes, field widths and the breakpoint entry layout of the envelope
// interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package bei_pkg;

  // item kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_SEEK    = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  // segment modes
  localparam logic MODE_HOLD   = 1'b0;
  localparam logic MODE_LINEAR = 1'b1;

  // field widths
  localparam int KIND_W        = 2;
  localparam int ENTRY_INDEX_W = 4;
  localparam int FRAME_W       = 32;
  localparam int LEVEL_W       = 32;
  localparam int POINT_COUNT_W = 5;

  // validity reported after the last breakpoint
  localparam logic [FRAME_W-1:0] HOLD_FOREVER = 32'hFFFF_FFFF;

  // one breakpoint as stored in the table memory
  typedef struct packed {
    logic [FRAME_W-1:0]        frame;
    logic signed [LEVEL_W-1:0] level;
    logic                      mode;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/breakpoint_envelope_interpolator.sv -----
// a write item is stored on acceptance; a seek or advance walks the table with a read and
//   a check state per breakpoint visited, then passes the result into the output register;
//   a linear segment adds setup, one 32x32 multiply, a 64-step serial divide and rounding fix
// throughput: one item at a time; the table walk and the 1-bit-per-cycle divider set it
// reset: position clears to 0, point count to 1; the table memory is not cleared
`default_nettype none

// ----------------------------------------------------------------------------
// breakpoint_envelope_interpolator
// breakpoint table in a synchronous memory with one write and one read port, walked entry by entry
// to find the active segment, then hold or linear interpolation with a serial
// restoring divider
// ----------------------------------------------------------------------------
module breakpoint_envelope_interpolator
  import bei_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        point_count_we_i,
  input  wire logic [POINT_COUNT_W-1:0]    point_count_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [KIND_W-1:0]           kind_i,
  input  wire logic [ENTRY_INDEX_W-1:0]    entry_index_i,
  input  wire logic [FRAME_W-1:0]          entry_frame_i,
  input  wire logic signed [LEVEL_W-1:0]   entry_level_i,
  input  wire logic                        entry_mode_i,
  input  wire logic [FRAME_W-1:0]          position_arg_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [LEVEL_W-1:0]        level_out_o,
  output logic [FRAME_W-1:0]               valid_frames_o
);

  localparam int IdxW  = $clog2(MAX_POINTS);
  localparam int CntW  = $clog2(MAX_POINTS + 1);
  localparam int PcW   = (CntW > POINT_COUNT_W) ? CntW : POINT_COUNT_W;
  localparam int SlotW = (CntW > ENTRY_INDEX_W) ? CntW : ENTRY_INDEX_W;
  localparam int ProdW = 2 * FRAME_W;
  localparam int QuoW  = FRAME_W + 1;
  localparam int SumW  = LEVEL_W + 3;
  localparam logic [PcW-1:0]   MaxPts   = PcW'(MAX_POINTS);
  localparam logic [SlotW-1:0] MaxSlots = SlotW'(MAX_POINTS);
  localparam logic [5:0]       LastStep = 6'd63;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                state_q, state_d;
  logic [POINT_COUNT_W-1:0]  point_count_q;
  logic [FRAME_W-1:0]        pos_q, pos_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic                      have_start_q, have_start_d;
  entry_t                    start_q, start_d;
  entry_t                    end_q, end_d;
  entry_t                    rd_q;
  entry_t                    mem_q [MAX_POINTS];
  logic                      neg_q, neg_d;
  logic [QuoW-1:0]           mag_q, mag_d;
  logic [FRAME_W-1:0]        through_q, through_d;
  logic [FRAME_W-1:0]        dur_q, dur_d;
  logic [ProdW-1:0]          quo_q, quo_d;
  logic [FRAME_W-1:0]        rem_q, rem_d;
  logic [5:0]                step_q, step_d;
  logic signed [LEVEL_W-1:0] res_level_q, res_level_d;
  logic [FRAME_W-1:0]        res_valid_q, res_valid_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [LEVEL_W-1:0] level_out_q, level_out_d;
  logic [FRAME_W-1:0]        valid_frames_q, valid_frames_d;

  logic                      in_xfer, out_xfer;
  logic                      mem_we;
  logic [IdxW-1:0]           last_idx;
  logic [PcW-1:0]            pc_wide, used_n;

  // points in use, clamped to one and to the table depth
  always_comb begin
    pc_wide = PcW'(point_count_q);
    if (pc_wide == '0) begin
      used_n = PcW'(1);
    end else if (pc_wide > MaxPts) begin
      used_n = MaxPts;
    end else begin
      used_n = pc_wide;
    end
    last_idx = IdxW'(used_n - PcW'(1));
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;
  assign mem_we     = in_xfer && (kind_i == KIND_WRITE) &&
                      (SlotW'(entry_index_i) < MaxSlots);

  // breakpoint table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[IdxW'(entry_index_i)] <= '{frame: entry_frame_i, level: entry_level_i,
                                      mode: entry_mode_i};
    end
    rd_q <= mem_q[idx_q];
  end

  // sequencer and datapath next state
  always_comb begin
    logic [QuoW-1:0]      diff;
    logic [FRAME_W:0]     rem_ext;
    logic [FRAME_W:0]     rem_sub;
    logic signed [SumW-1:0] sx, qx, v;

    state_d        = state_q;
    pos_d          = pos_q;
    idx_d          = idx_q;
    have_start_d   = have_start_q;
    start_d        = start_q;
    end_d          = end_q;
    neg_d          = neg_q;
    mag_d          = mag_q;
    through_d      = through_q;
    dur_d          = dur_q;
    quo_d          = quo_q;
    rem_d          = rem_q;
    step_d         = step_q;
    res_level_d    = res_level_q;
    res_valid_d    = res_valid_q;
    out_valid_d    = out_valid_q;
    level_out_d    = level_out_q;
    valid_frames_d = valid_frames_q;
    diff           = '0;
    rem_ext        = '0;
    rem_sub        = '0;
    sx             = '0;
    qx             = '0;
    v              = '0;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer && (kind_i == KIND_SEEK || kind_i == KIND_ADVANCE)) begin
          pos_d        = (kind_i == KIND_SEEK) ? position_arg_i : pos_q + position_arg_i;
          idx_d        = '0;
          have_start_d = 1'b0;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      // compare the fetched breakpoint against the position
      S_CHECK: begin
        if (rd_q.frame > pos_q) begin
          end_d = rd_q;
          if (!have_start_q) begin
            res_level_d = rd_q.level;
            res_valid_d = rd_q.frame - pos_q;
            state_d     = S_DONE;
          end else if (start_q.mode == MODE_HOLD || rd_q.frame == start_q.frame) begin
            res_level_d = start_q.level;
            res_valid_d = rd_q.frame - pos_q;
            state_d     = S_DONE;
          end else begin
            state_d = S_PREP;
          end
        end else begin
          start_d      = rd_q;
          have_start_d = 1'b1;
          if (idx_q == last_idx) begin
            res_level_d = rd_q.level;
            res_valid_d = HOLD_FOREVER;
            state_d     = S_DONE;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_READ;
          end
        end
      end
      // level difference as sign and magnitude, segment length and offset
      S_PREP: begin
        diff      = {end_q.level[LEVEL_W-1], end_q.level} -
                    {start_q.level[LEVEL_W-1], start_q.level};
        neg_d     = diff[QuoW-1];
        mag_d     = diff[QuoW-1] ? (~diff + QuoW'(1)) : diff;
        through_d = pos_q - start_q.frame;
        dur_d     = end_q.frame - start_q.frame;
        state_d   = S_MUL;
      end
      // magnitude times offset; a magnitude of 2^32 is a plain shift
      S_MUL: begin
        if (mag_q[QuoW-1]) begin
          quo_d = {through_q, {FRAME_W{1'b0}}};
        end else begin
          quo_d = ProdW'(mag_q[FRAME_W-1:0]) * ProdW'(through_q);
        end
        rem_d   = '0;
        step_d  = '0;
        state_d = S_DIV;
      end
      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        rem_ext = {rem_q, quo_q[ProdW-1]};
        rem_sub = rem_ext - {1'b0, dur_q};
        if (rem_ext >= {1'b0, dur_q}) begin
          rem_d = rem_sub[FRAME_W-1:0];
          quo_d = {quo_q[ProdW-2:0], 1'b1};
        end else begin
          rem_d = rem_ext[FRAME_W-1:0];
          quo_d = {quo_q[ProdW-2:0], 1'b0};
        end
        step_d = step_q + 6'd1;
        if (step_q == LastStep) begin
          state_d = S_FIN;
        end
      end
      // apply the quotient and truncate toward zero as a whole
      S_FIN: begin
        sx = SumW'(start_q.level);
        qx = SumW'({2'b00, quo_q[QuoW-1:0]});
        if (!neg_q) begin
          v = sx + qx;
          if (rem_q != '0 && v < 0) begin
            v = v + SumW'(1);
          end
        end else begin
          v = sx - qx;
          if (rem_q != '0 && v > 0) begin
            v = v - SumW'(1);
          end
        end
        res_level_d = v[LEVEL_W-1:0];
        res_valid_d = FRAME_W'(1);
        state_d     = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          level_out_d    = res_level_q;
          valid_frames_d = res_valid_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      point_count_q <= POINT_COUNT_W'(1);
      pos_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (point_count_we_i) begin
        point_count_q <= point_count_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q          <= idx_d;
    have_start_q   <= have_start_d;
    start_q        <= start_d;
    end_q          <= end_d;
    neg_q          <= neg_d;
    mag_q          <= mag_d;
    through_q      <= through_d;
    dur_q          <= dur_d;
    quo_q          <= quo_d;
    rem_q          <= rem_d;
    step_q         <= step_d;
    res_level_q    <= res_level_d;
    res_valid_q    <= res_valid_d;
    level_out_q    <= level_out_d;
    valid_frames_q <= valid_frames_d;
  end

  assign out_valid_o    = out_valid_q;
  assign level_out_o    = level_out_q;
  assign valid_frames_o = valid_frames_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bei_checker.sv -----
`default_nettype none

// ----------------------------------------------------------------------------
// bei_checker
// port-level checks of the envelope interpolator: result ordering against
// accepted evaluation items and output register behavior
// ----------------------------------------------------------------------------
`include "breakpoint_envelope_interpolator_macros.svh"

module bei_checker
  import bei_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic [KIND_W-1:0]         kind_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic signed [LEVEL_W-1:0] level_out_o,
  input wire logic [FRAME_W-1:0]        valid_frames_o
);

  logic       in_xfer, eval_xfer, write_xfer, out_xfer, out_stall;
  logic [1:0] pend_q, pend_d;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign eval_xfer  = in_xfer && (kind_i == KIND_SEEK || kind_i == KIND_ADVANCE);
  assign write_xfer = in_xfer && (kind_i == KIND_WRITE);
  assign out_xfer   = out_valid_o && out_ready_i;
  assign out_stall  = out_valid_o && !out_ready_i;

  // evaluation items accepted but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (eval_xfer && !out_xfer) begin
      pend_d = pend_q + 2'd1;
    end else if (!eval_xfer && out_xfer) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // a stalled result holds
  `BEI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
                   out_valid_o && $stable(level_out_o) && $stable(valid_frames_o))
  // no result without an accepted seek or advance
  `BEI_ASSERT_NOW(a_no_extra, clk_i, rst_ni, out_valid_o, pend_q != 2'd0)
  // with one result waiting and one in flight no further item is taken
  `BEI_ASSERT_NOW(a_full_stall, clk_i, rst_ni, pend_q == 2'd2, !in_ready_o)
  // a write item produces no result
  `BEI_ASSERT_NEXT(a_write_silent, clk_i, rst_ni, write_xfer && pend_q == 2'd0, !out_valid_o)

endmodule

bind breakpoint_envelope_interpolator bei_checker u_bei_checker (.*);

`default_nettype wire

// ----- dv/breakpoint_envelope_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// breakpoint_envelope_checker
// watches the configuration port and both channels of the envelope
// interpolator, keeps its own breakpoint table and play position, predicts
// each level and validity span, and compares every result transfer with the
// oldest prediction
// ----------------------------------------------------------------------------
module breakpoint_envelope_checker
  import bei_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration
  input  wire logic                      point_count_we_i,
  input  wire logic [POINT_COUNT_W-1:0]  point_count_i,
  // input channel
  input  wire logic                      in_valid_i,
  input  wire logic                      in_ready_i,
  input  wire logic [KIND_W-1:0]         kind_i,
  input  wire logic [ENTRY_INDEX_W-1:0]  entry_index_i,
  input  wire logic [FRAME_W-1:0]        entry_frame_i,
  input  wire logic signed [LEVEL_W-1:0] entry_level_i,
  input  wire logic                      entry_mode_i,
  input  wire logic [FRAME_W-1:0]        position_arg_i,
  // output channel
  input  wire logic                      out_valid_i,
  input  wire logic                      out_ready_i,
  input  wire logic signed [LEVEL_W-1:0] level_out_i,
  input  wire logic [FRAME_W-1:0]        valid_frames_i,
  // status
  output int                             mismatch_count_o,
  output int                             pending_count_o,
  output int                             result_count_o
);

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic [FRAME_W-1:0]        valid_frames;
  } envelope_point_t;

  logic [FRAME_W-1:0]        bp_frame [MAX_POINTS];
  logic signed [LEVEL_W-1:0] bp_level [MAX_POINTS];
  logic                      bp_mode  [MAX_POINTS];
  logic [FRAME_W-1:0]        play_pos;
  logic [POINT_COUNT_W-1:0]  active_count;
  envelope_point_t           expected_envelope_q [$];

  // level and validity span at a play position, from the current table
  function automatic envelope_point_t envelope_at(input logic [FRAME_W-1:0] pos);
    envelope_point_t res;
    int              used;
    int              start_slot;
    int              end_slot;
    int              i;
    logic [FRAME_W-1:0] dur;
    logic [FRAME_W-1:0] through;
    longint          lvl_start;
    longint          lvl_end;
    longint          diff;
    longint          lvl;
    logic [63:0]     mag;
    logic [63:0]     prod;
    logic [63:0]     quo;
    logic [63:0]     rem;
    used = int'(active_count);
    if (used < 1) used = 1;
    if (used > MAX_POINTS) used = MAX_POINTS;
    start_slot = -1;
    end_slot   = -1;
    // last point at or before the position, first point past it
    for (i = 0; i < used; i++) begin
      if (end_slot < 0) begin
        if (bp_frame[i] > pos) end_slot = i;
        else start_slot = i;
      end
    end
    if (start_slot < 0) begin
      res.level        = bp_level[0];
      res.valid_frames = bp_frame[0] - pos;
    end else if (end_slot < 0) begin
      res.level        = bp_level[start_slot];
      res.valid_frames = HOLD_FOREVER;
    end else begin
      dur     = bp_frame[end_slot] - bp_frame[start_slot];
      through = pos - bp_frame[start_slot];
      if (bp_mode[start_slot] == MODE_HOLD || dur == '0) begin
        res.level        = bp_level[start_slot];
        res.valid_frames = dur - through;
      end else begin
        // exact product, then truncation of the whole result toward zero
        lvl_start = bp_level[start_slot];
        lvl_end   = bp_level[end_slot];
        diff      = lvl_end - lvl_start;
        mag       = (diff < 0) ? $unsigned(-diff) : $unsigned(diff);
        prod      = mag * {32'd0, through};
        quo       = prod / {32'd0, dur};
        rem       = prod % {32'd0, dur};
        if (diff >= 0) begin
          lvl = lvl_start + $signed(quo);
          if (rem != 0 && lvl < 0) lvl = lvl + 1;
        end else begin
          lvl = lvl_start - $signed(quo);
          if (rem != 0 && lvl > 0) lvl = lvl - 1;
        end
        res.level        = lvl[LEVEL_W-1:0];
        res.valid_frames = 32'd1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    envelope_point_t want;
    if (!rst_ni) begin
      play_pos         = '0;
      active_count     = POINT_COUNT_W'(1);
      expected_envelope_q.delete();
      mismatch_count_o = 0;
      result_count_o   = 0;
      pending_count_o  = 0;
    end else begin
      // result transfer against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        result_count_o++;
        if (expected_envelope_q.size() == 0) begin
          $error("result with nothing expected: level_out %0d, valid_frames %0d",
                 level_out_i, valid_frames_i);
          mismatch_count_o++;
        end else begin
          want = expected_envelope_q.pop_front();
          if (level_out_i !== want.level) begin
            $error("level_out: expected %0d, actual %0d", want.level, level_out_i);
            mismatch_count_o++;
          end
          if (valid_frames_i !== want.valid_frames) begin
            $error("valid_frames: expected %0d, actual %0d",
                   want.valid_frames, valid_frames_i);
            mismatch_count_o++;
          end
        end
      end

      // register write
      if (point_count_we_i) active_count = point_count_i;

      // input transfer
      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          KIND_WRITE: begin
            bp_frame[entry_index_i] = entry_frame_i;
            bp_level[entry_index_i] = entry_level_i;
            bp_mode[entry_index_i]  = entry_mode_i;
          end
          KIND_SEEK: begin
            play_pos = position_arg_i;
            expected_envelope_q.push_back(envelope_at(play_pos));
          end
          KIND_ADVANCE: begin
            play_pos = play_pos + position_arg_i;
            expected_envelope_q.push_back(envelope_at(play_pos));
          end
          default: ;
        endcase
      end
      pending_count_o = expected_envelope_q.size();
    end
  end

endmodule

// ----- dv/tb_breakpoint_envelope_interpolator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_breakpoint_envelope_interpolator
// drives breakpoint writes, seeks and advances into the envelope interpolator
// under random idling on both channels, across several point-count settings;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_breakpoint_envelope_interpolator;
  import bei_pkg::*;

  localparam int                MAX_POINTS     = 16;
  localparam logic [KIND_W-1:0] KIND_UNUSED    = 2'd3;
  localparam int                SETTLE_CYCLES  = 128;
  localparam int                WATCHDOG_LIMIT = 4000;
  localparam int                PHASE_ITEMS    = 65;

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      point_count_we   = 1'b0;
  logic [POINT_COUNT_W-1:0]  point_count      = '0;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic [KIND_W-1:0]         kind             = '0;
  logic [ENTRY_INDEX_W-1:0]  entry_index      = '0;
  logic [FRAME_W-1:0]        entry_frame      = '0;
  logic signed [LEVEL_W-1:0] entry_level      = '0;
  logic                      entry_mode       = 1'b0;
  logic [FRAME_W-1:0]        position_arg     = '0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  logic signed [LEVEL_W-1:0] level_out;
  logic [FRAME_W-1:0]        valid_frames;

  int                        mismatch_count;
  int                        pending_count;
  int                        result_count;
  int                        stall_cycles     = 0;
  int                        items_sent       = 0;
  int                        settings_applied = 0;
  int                        used_points      = 1;
  bit                        quiet            = 1'b0;
  logic [FRAME_W-1:0]        table_frame [MAX_POINTS];

  breakpoint_envelope_interpolator #(
    .MAX_POINTS (MAX_POINTS)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .point_count_we_i (point_count_we),
    .point_count_i    (point_count),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .entry_index_i    (entry_index),
    .entry_frame_i    (entry_frame),
    .entry_level_i    (entry_level),
    .entry_mode_i     (entry_mode),
    .position_arg_i   (position_arg),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .level_out_o      (level_out),
    .valid_frames_o   (valid_frames)
  );

  breakpoint_envelope_checker #(
    .MAX_POINTS (MAX_POINTS)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .point_count_we_i (point_count_we),
    .point_count_i    (point_count),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .kind_i           (kind),
    .entry_index_i    (entry_index),
    .entry_frame_i    (entry_frame),
    .entry_level_i    (entry_level),
    .entry_mode_i     (entry_mode),
    .position_arg_i   (position_arg),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .level_out_i      (level_out),
    .valid_frames_i   (valid_frames),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .result_count_o   (result_count)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // result side backpressure
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 28);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_breakpoint_envelope_interpolator: done, errors");
    $finish;
  end

  // present one item and hold it until the transfer
  task automatic issue_item(input logic [KIND_W-1:0] k, input logic [ENTRY_INDEX_W-1:0] idx,
                            input logic [FRAME_W-1:0] frame,
                            input logic signed [LEVEL_W-1:0] lvl, input logic mode,
                            input logic [FRAME_W-1:0] arg);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    kind         = k;
    entry_index  = idx;
    entry_frame  = frame;
    entry_level  = lvl;
    entry_mode   = mode;
    position_arg = arg;
    in_valid     = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k == KIND_WRITE) table_frame[idx] = frame;
    if (k != KIND_UNUSED) items_sent++;
  endtask

  // stop sending, let every result come back and the block go quiet
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_point_count(input logic [POINT_COUNT_W-1:0] value);
    @(negedge clk);
    point_count_we = 1'b1;
    point_count    = value;
    @(negedge clk);
    point_count_we = 1'b0;
    used_points = (value == 0) ? 1 : ((value > MAX_POINTS) ? MAX_POINTS : int'(value));
    settings_applied++;
  endtask

  // rising table with random spacing, occasionally repeated frames
  task automatic lay_out_table();
    logic [FRAME_W-1:0] frame;
    int                 gap_bits;
    int                 i;
    frame    = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4096);
    gap_bits = $urandom_range(0, 24);
    for (i = 0; i < MAX_POINTS; i++) begin
      issue_item(KIND_WRITE, ENTRY_INDEX_W'(i), frame,
                 $urandom_range(1) ? $urandom : $urandom_range(0, 2000) - 1000,
                 1'($urandom_range(1)), $urandom);
      if ($urandom_range(9) != 0) frame = frame + $urandom_range(1, 1 << gap_bits);
    end
  endtask

  // mostly positions inside the table, some noise and wild jumps
  task automatic run_traffic(input int budget);
    int                 stop_at;
    int                 roll;
    int                 slot;
    logic [FRAME_W-1:0] span;
    logic [FRAME_W-1:0] pos;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        lay_out_table();
      end else if (roll < 14) begin
        issue_item(KIND_WRITE, ENTRY_INDEX_W'($urandom), $urandom, $urandom,
                   1'($urandom), $urandom);
      end else if (roll < 16) begin
        issue_item(KIND_UNUSED, ENTRY_INDEX_W'($urandom), $urandom, $urandom,
                   1'($urandom), $urandom);
      end else if (roll < 58) begin
        slot = $urandom_range(0, used_points - 1);
        span = (slot + 1 < used_points) ? table_frame[slot + 1] - table_frame[slot] : 32'd64;
        pos  = table_frame[slot] + ((span == 0) ? 32'd0 : ($urandom % span));
        if ($urandom_range(9) == 0) pos = table_frame[slot] - 1;
        issue_item(KIND_SEEK, ENTRY_INDEX_W'($urandom), $urandom, $urandom,
                   1'($urandom), pos);
      end else if (roll < 85) begin
        issue_item(KIND_ADVANCE, ENTRY_INDEX_W'($urandom), $urandom, $urandom,
                   1'($urandom), $urandom_range(0, 1 << $urandom_range(0, 16)));
      end else if (roll < 93) begin
        issue_item(KIND_SEEK, ENTRY_INDEX_W'($urandom), $urandom, $urandom,
                   1'($urandom), $urandom);
      end else begin
        issue_item(KIND_ADVANCE, ENTRY_INDEX_W'($urandom), $urandom, $urandom,
                   1'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    logic [POINT_COUNT_W-1:0] phase_counts [6];
    int                       failures;
    int                       i;
    phase_counts = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd9, 5'd17};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table: extremes of level, frame, a falling and a rising ramp,
    // a hold, a point out of order and a point at the last frame
    set_point_count(5'd6);
    issue_item(KIND_WRITE, 4'd0, 32'd100, 32'sh7FFF_FFFF, MODE_LINEAR, 32'd0);
    issue_item(KIND_WRITE, 4'd1, 32'd200, 32'sh8000_0000, MODE_HOLD, 32'd0);
    issue_item(KIND_WRITE, 4'd2, 32'd300, -32'sd7, MODE_LINEAR, 32'd0);
    issue_item(KIND_WRITE, 4'd3, 32'd310, 32'sd10, MODE_LINEAR, 32'd0);
    issue_item(KIND_WRITE, 4'd4, 32'd50, 32'sd0, MODE_HOLD, 32'hFFFF_FFFF);
    issue_item(KIND_WRITE, 4'd5, 32'hFFFF_FFFF, 32'sd123, MODE_HOLD, 32'd0);
    for (i = 6; i < MAX_POINTS; i++) begin
      issue_item(KIND_WRITE, ENTRY_INDEX_W'(i), 32'd400 + 32'(i * 100),
                 (i % 2 == 1) ? -(i * 1000) : i * 777, 1'(i % 2), 32'd0);
    end

    // before the first point, inside both ramps, a hold, out of order point,
    // past the last point, wrap of the position, the unused kind
    issue_item(KIND_SEEK, '0, '0, '0, 1'b0, 32'd0);
    issue_item(KIND_SEEK, '0, '0, '0, 1'b0, 32'd150);
    issue_item(KIND_SEEK, '0, '0, '0, 1'b0, 32'd250);
    issue_item(KIND_SEEK, '0, '0, '0, 1'b0, 32'd303);
    issue_item(KIND_ADVANCE, '0, '0, '0, 1'b0, 32'd2);
    issue_item(KIND_SEEK, '0, '0, '0, 1'b0, 32'd310);
    issue_item(KIND_SEEK, '0, '0, '0, 1'b0, 32'hFFFF_FFFF);
    issue_item(KIND_ADVANCE, '0, '0, '0, 1'b0, 32'd1);
    issue_item(KIND_ADVANCE, '0, '0, '0, 1'b0, 32'h7FFF_FFFF);
    issue_item(KIND_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);

    // random phases, each under its own point count; one without any idling
    for (i = 0; i < 6; i++) begin
      drain_and_settle();
      set_point_count(phase_counts[i]);
      quiet = (i == 2);
      run_traffic(PHASE_ITEMS);
    end
    quiet = 1'b0;

    // final drain, then the verdict
    drain_and_settle();
    failures = mismatch_count + pending_count;
    if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
    $display("covered %0d items and %0d checked results over %0d point-count settings",
             items_sent, result_count, settings_applied);
    if (failures == 0) begin
      $display("tb_breakpoint_envelope_interpolator: done, clean");
    end else begin
      $display("tb_breakpoint_envelope_interpolator: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bei_pkg.sv
hw/rtl/breakpoint_envelope_interpolator.sv
hw/rtl/bei_checker.sv
dv/breakpoint_envelope_checker.sv
dv/tb_breakpoint_envelope_interpolator.sv
